>>> src/wav_stream_pcm_decoder_defines.svh
// assertion macros for the wav stream decoder checker
`ifndef WAV_STREAM_PCM_DECODER_DEFINES_SVH
`define WAV_STREAM_PCM_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define WSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    localparam int MAX_SAMPLE_BYTES = 4;
    localparam int BPS_W            = $clog2(MAX_SAMPLE_BYTES + 1);
    localparam int SBC_W            = $clog2(MAX_SAMPLE_BYTES);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16 + BPS_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [7:0] PCM8_BIAS = 8'h80;

    localparam logic [4:0] RIFF_TAG_END      = 5'd3;
    localparam logic [4:0] RIFF_HEADER_END   = 5'd11;
    localparam logic [4:0] CHUNK_TAG_BYTES   = 5'd4;
    localparam logic [4:0] CHUNK_HEADER_END  = 5'd7;

    localparam logic [4:0] FMT_OFF_CH_LO   = 5'd2;
    localparam logic [4:0] FMT_OFF_CH_HI   = 5'd3;
    localparam logic [4:0] FMT_OFF_RATE_0  = 5'd4;
    localparam logic [4:0] FMT_OFF_RATE_1  = 5'd5;
    localparam logic [4:0] FMT_OFF_RATE_2  = 5'd6;
    localparam logic [4:0] FMT_OFF_RATE_3  = 5'd7;
    localparam logic [4:0] FMT_OFF_BITS_LO = 5'd14;
    localparam logic [4:0] FMT_OFF_BITS_HI = 5'd15;
    localparam logic [4:0] FMT_FIELD_END   = 5'd16;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HDR,
        PH_FMT,
        PH_SKIP,
        PH_DATA,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NOT_RIFF   = 2'd0,
        ERR_NOT_WAVE   = 2'd1,
        ERR_BAD_FORMAT = 2'd2,
        ERR_TOO_WIDE   = 2'd3
    } err_t;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } back_state_t;

    typedef struct packed {
        kind_t                 kind;
        logic [15:0]           sample;
        logic [15:0]           channels;
        logic [31:0]           sample_freq;
        logic [15:0]           bit_depth;
        err_t                  error_code;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } result_cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] sample;
        logic [15:0] channels;
        logic [31:0] sample_freq;
        logic [15:0] bit_depth;
        logic [31:0] frame_count;
        err_t        error_code;
    } result_t;

endpackage

`default_nettype wire

>>> src/wsd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  wsd_pkg::result_cmd_t push_cmd,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output wsd_pkg::result_cmd_t pop_cmd
);
    import wsd_pkg::*;

    result_cmd_t            entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> src/wsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  logic [7:0]           data_byte,
    input  logic                 first,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output wsd_pkg::result_cmd_t cmd
);
    import wsd_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [4:0]  byte_index_reg;
    logic [4:0]  byte_index_next;
    logic [31:0] tag_reg;
    logic [31:0] tag_next;
    logic [31:0] chunk_length_reg;
    logic [31:0] chunk_length_next;
    logic        fmt_seen_reg;
    logic        fmt_seen_next;
    logic [15:0] channels_reg;
    logic [15:0] channels_next;
    logic [31:0] rate_reg;
    logic [31:0] rate_next;
    logic [15:0] bits_reg;
    logic [15:0] bits_next;
    logic [31:0] data_remaining_reg;
    logic [31:0] data_remaining_next;
    logic [7:0]  prev_byte_reg;
    logic [7:0]  prev_byte_next;
    logic [SBC_W-1:0] sample_count_reg;
    logic [SBC_W-1:0] sample_count_next;

    phase_t      cur_phase;
    logic [4:0]  cur_index;
    logic [31:0] cur_tag;
    logic [31:0] cur_length;
    logic        cur_fmt_seen;
    logic [15:0] cur_channels;
    logic [31:0] cur_rate;
    logic [15:0] cur_bits;
    logic [31:0] cur_remaining;
    logic [7:0]  cur_prev;
    logic [SBC_W-1:0] cur_count;

    logic               accept;
    logic [31:0]        tag_shifted;
    logic [31:0]        length_ored;
    logic [31:0]        length_dec;
    logic [31:0]        remaining_dec;
    logic [12:0]        bps_full;
    logic [BPS_W-1:0]   bps;
    logic [BPS_W:0]     count_inc;
    logic [15:0]        pcm_word;
    logic               emit;
    kind_t              emit_kind;
    err_t               emit_err;

    assign byte_ready = cmd_ready;
    assign accept     = byte_valid && cmd_ready;

    always_comb
    begin
        cur_phase     = first ? PH_RIFF : phase_reg;
        cur_index     = first ? '0 : byte_index_reg;
        cur_tag       = first ? '0 : tag_reg;
        cur_length    = first ? '0 : chunk_length_reg;
        cur_fmt_seen  = first ? 1'b0 : fmt_seen_reg;
        cur_channels  = first ? '0 : channels_reg;
        cur_rate      = first ? '0 : rate_reg;
        cur_bits      = first ? '0 : bits_reg;
        cur_remaining = first ? '0 : data_remaining_reg;
        cur_prev      = first ? '0 : prev_byte_reg;
        cur_count     = first ? '0 : sample_count_reg;

        tag_shifted   = {cur_tag[23:0], data_byte};
        length_ored   = cur_length | ({24'b0, data_byte} << {cur_index[1:0], 3'b000});
        length_dec    = cur_length - 32'd1;
        remaining_dec = cur_remaining - 32'd1;
        bps_full      = cur_bits[15:3];
        bps           = bps_full[BPS_W-1:0];
        count_inc     = (BPS_W + 1)'(cur_count) + 1'b1;
        pcm_word      = (bps == BPS_W'(1)) ? {data_byte ^ PCM8_BIAS, 8'h00}
                                           : {data_byte, cur_prev};

        phase_next          = phase_reg;
        byte_index_next     = byte_index_reg;
        tag_next            = tag_reg;
        chunk_length_next   = chunk_length_reg;
        fmt_seen_next       = fmt_seen_reg;
        channels_next       = channels_reg;
        rate_next           = rate_reg;
        bits_next           = bits_reg;
        data_remaining_next = data_remaining_reg;
        prev_byte_next      = prev_byte_reg;
        sample_count_next   = sample_count_reg;

        emit      = 1'b0;
        emit_kind = KIND_SAMPLE;
        emit_err  = ERR_NOT_RIFF;

        if (accept)
        begin
            phase_next          = cur_phase;
            byte_index_next     = cur_index;
            tag_next            = cur_tag;
            chunk_length_next   = cur_length;
            fmt_seen_next       = cur_fmt_seen;
            channels_next       = cur_channels;
            rate_next           = cur_rate;
            bits_next           = cur_bits;
            data_remaining_next = cur_remaining;
            prev_byte_next      = cur_prev;
            sample_count_next   = cur_count;

            unique case (cur_phase)
                PH_RIFF:
                begin
                    tag_next = tag_shifted;
                    priority if (cur_index == RIFF_TAG_END && tag_shifted != TAG_RIFF)
                    begin
                        phase_next = PH_HALT;
                        emit       = 1'b1;
                        emit_kind  = KIND_ERROR;
                        emit_err   = ERR_NOT_RIFF;
                    end
                    else if (cur_index == RIFF_HEADER_END)
                    begin
                        if (tag_shifted != TAG_WAVE)
                        begin
                            phase_next = PH_HALT;
                            emit       = 1'b1;
                            emit_kind  = KIND_ERROR;
                            emit_err   = ERR_NOT_WAVE;
                        end
                        else
                        begin
                            phase_next      = PH_HDR;
                            byte_index_next = '0;
                        end
                    end
                    else
                    begin
                        byte_index_next = cur_index + 1'b1;
                    end
                end
                PH_HDR:
                begin
                    if (cur_index < CHUNK_TAG_BYTES)
                    begin
                        tag_next = tag_shifted;
                        if (cur_index == '0)
                        begin
                            chunk_length_next = '0;
                        end
                    end
                    else
                    begin
                        chunk_length_next = length_ored;
                    end
                    if (cur_index < CHUNK_HEADER_END)
                    begin
                        byte_index_next = cur_index + 1'b1;
                    end
                    else
                    begin
                        byte_index_next = '0;
                        priority if (cur_tag == TAG_FMT)
                        begin
                            fmt_seen_next = 1'b1;
                            channels_next = '0;
                            rate_next     = '0;
                            bits_next     = '0;
                            phase_next    = (length_ored != '0) ? PH_FMT : PH_HDR;
                        end
                        else if (cur_tag != TAG_DATA)
                        begin
                            phase_next = (length_ored != '0) ? PH_SKIP : PH_HDR;
                        end
                        else if (!cur_fmt_seen || cur_channels == '0 || bps_full == '0)
                        begin
                            phase_next = PH_HALT;
                            emit       = 1'b1;
                            emit_kind  = KIND_ERROR;
                            emit_err   = ERR_BAD_FORMAT;
                        end
                        else if (bps_full > 13'(MAX_SAMPLE_BYTES))
                        begin
                            phase_next = PH_HALT;
                            emit       = 1'b1;
                            emit_kind  = KIND_ERROR;
                            emit_err   = ERR_TOO_WIDE;
                        end
                        else
                        begin
                            data_remaining_next = length_ored;
                            prev_byte_next      = '0;
                            sample_count_next   = '0;
                            phase_next          = (length_ored != '0) ? PH_DATA : PH_HALT;
                            emit                = 1'b1;
                            emit_kind           = KIND_REPORT;
                        end
                    end
                end
                PH_FMT:
                begin
                    unique case (cur_index)
                        FMT_OFF_CH_LO:   channels_next[7:0]  = data_byte;
                        FMT_OFF_CH_HI:   channels_next[15:8] = data_byte;
                        FMT_OFF_RATE_0:  rate_next[7:0]      = data_byte;
                        FMT_OFF_RATE_1:  rate_next[15:8]     = data_byte;
                        FMT_OFF_RATE_2:  rate_next[23:16]    = data_byte;
                        FMT_OFF_RATE_3:  rate_next[31:24]    = data_byte;
                        FMT_OFF_BITS_LO: bits_next[7:0]      = data_byte;
                        FMT_OFF_BITS_HI: bits_next[15:8]     = data_byte;
                        default:         channels_next       = cur_channels;
                    endcase
                    chunk_length_next = length_dec;
                    if (length_dec == '0)
                    begin
                        phase_next      = PH_HDR;
                        byte_index_next = '0;
                    end
                    else if (cur_index < FMT_FIELD_END)
                    begin
                        byte_index_next = cur_index + 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    chunk_length_next = length_dec;
                    if (length_dec == '0)
                    begin
                        phase_next      = PH_HDR;
                        byte_index_next = '0;
                    end
                end
                PH_DATA:
                begin
                    prev_byte_next      = data_byte;
                    data_remaining_next = remaining_dec;
                    if (remaining_dec == '0)
                    begin
                        phase_next = PH_HALT;
                    end
                    if (count_inc < {1'b0, bps})
                    begin
                        sample_count_next = count_inc[SBC_W-1:0];
                    end
                    else
                    begin
                        sample_count_next = '0;
                        emit              = 1'b1;
                        emit_kind         = KIND_SAMPLE;
                    end
                end
                PH_HALT:
                begin
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = cur_phase;
                end
            endcase
        end

        cmd_valid      = emit;
        cmd.kind       = emit_kind;
        cmd.sample     = (emit_kind == KIND_SAMPLE) ? pcm_word : 16'h0000;
        cmd.channels   = cur_channels;
        cmd.sample_freq = cur_rate;
        cmd.bit_depth  = cur_bits;
        cmd.error_code = (emit_kind == KIND_ERROR) ? emit_err : ERR_NOT_RIFF;
        cmd.dividend   = length_ored;
        cmd.divisor    = {{BPS_W{1'b0}}, cur_channels} * {{16{1'b0}}, bps};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_RIFF;
            byte_index_reg     <= '0;
            tag_reg            <= '0;
            chunk_length_reg   <= '0;
            fmt_seen_reg       <= 1'b0;
            channels_reg       <= '0;
            rate_reg           <= '0;
            bits_reg           <= '0;
            data_remaining_reg <= '0;
            prev_byte_reg      <= '0;
            sample_count_reg   <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            byte_index_reg     <= byte_index_next;
            tag_reg            <= tag_next;
            chunk_length_reg   <= chunk_length_next;
            fmt_seen_reg       <= fmt_seen_next;
            channels_reg       <= channels_next;
            rate_reg           <= rate_next;
            bits_reg           <= bits_next;
            data_remaining_reg <= data_remaining_next;
            prev_byte_reg      <= prev_byte_next;
            sample_count_reg   <= sample_count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/wsd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wsd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  wsd_pkg::result_cmd_t cmd,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wsd_pkg::result_t     out_word
);
    import wsd_pkg::*;

    back_state_t           state_reg;
    back_state_t           state_next;
    result_cmd_t           hold_reg;
    result_cmd_t           hold_next;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVIDEND_W-1:0] quot_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_CNT_W-1:0]  cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_reg;
    result_t               out_next;

    logic                  slot_free;
    logic                  load;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  quot_bit;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[DIVIDEND_W-1]};
        rem_sub   = rem_shift - {1'b0, hold_reg.divisor};
        quot_bit  = (rem_shift >= {1'b0, hold_reg.divisor});

        state_next = state_reg;
        hold_next  = hold_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        load       = 1'b0;
        cmd_ready  = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = (cmd.kind == KIND_REPORT) || slot_free;
                if (cmd_valid && cmd_ready)
                begin
                    if (cmd.kind == KIND_REPORT)
                    begin
                        hold_next  = cmd;
                        quot_next  = cmd.dividend;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = BK_DIV;
                    end
                    else
                    begin
                        load                 = 1'b1;
                        out_next.kind        = cmd.kind;
                        out_next.sample      = cmd.sample;
                        out_next.channels    = cmd.channels;
                        out_next.sample_freq = cmd.sample_freq;
                        out_next.bit_depth   = cmd.bit_depth;
                        out_next.frame_count = '0;
                        out_next.error_code  = cmd.error_code;
                    end
                end
            end
            BK_DIV:
            begin
                if (cnt_reg != DIV_CNT_W'(DIVIDEND_W))
                begin
                    // one quotient bit per cycle, restoring
                    rem_next  = quot_bit ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
                    quot_next = {quot_reg[DIVIDEND_W-2:0], quot_bit};
                    cnt_next  = cnt_reg + 1'b1;
                end
                else if (slot_free)
                begin
                    load                 = 1'b1;
                    out_next.kind        = hold_reg.kind;
                    out_next.sample      = hold_reg.sample;
                    out_next.channels    = hold_reg.channels;
                    out_next.sample_freq = hold_reg.sample_freq;
                    out_next.bit_depth   = hold_reg.bit_depth;
                    out_next.frame_count = quot_reg;
                    out_next.error_code  = hold_reg.error_code;
                    state_next           = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

>>> src/wav_stream_pcm_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming WAV/PCM decoder: takes a RIFF/WAVE file one byte per word on the
// input stream (tuser marks the first byte of a new file and restarts the
// parse), walks the subchunks, reads the fmt fields and emits one word per
// complete sample as signed 16-bit PCM, a format report at the data header
// and an error word when the header is unusable (the parse then halts until
// the next first byte). A byte is taken every cycle while the four-word queue
// between the parser and the output stage has room; samples and errors pass
// through the queue into the output register, while the format report first
// goes through the bit-serial divider (one quotient bit per cycle) that works
// out the frame count, so the input stalls only when the queue fills behind it.
module wav_stream_pcm_decoder (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic [0:0]   s_axis_tuser,   // first
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sample, channels, sample_freq, bit_depth, frame_count, error_code
    output logic [119:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser    // kind
);
    import wsd_pkg::*;

    result_cmd_t front_cmd;
    logic        front_valid;
    logic        front_ready;
    result_cmd_t back_cmd;
    logic        back_valid;
    logic        back_ready;
    result_t     out_word;

    wsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_axis_tvalid),
        .byte_ready (s_axis_tready),
        .data_byte  (s_axis_tdata),
        .first      (s_axis_tuser[0]),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    wsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tuser = out_word.kind;
    assign m_axis_tdata = {6'b0, out_word.error_code, out_word.frame_count,
                           out_word.bit_depth, out_word.sample_freq,
                           out_word.channels, out_word.sample};

endmodule

`default_nettype wire

>>> src/wsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "wav_stream_pcm_decoder_defines.svh"

module wsd_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    import wsd_pkg::*;

    `WSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")

    `WSD_ASSERT_NOW(a_sample_clean, m_axis_tvalid && m_axis_tuser == KIND_SAMPLE, m_axis_tdata[111:80] == '0 && m_axis_tdata[113:112] == '0, "sample word carries frame count or error")

    `WSD_ASSERT_NOW(a_report_clean, m_axis_tvalid && m_axis_tuser == KIND_REPORT, m_axis_tdata[15:0] == '0 && m_axis_tdata[113:112] == '0, "report word carries sample or error")

    `WSD_ASSERT_NOW(a_error_clean, m_axis_tvalid && m_axis_tuser == KIND_ERROR, m_axis_tdata[15:0] == '0 && m_axis_tdata[111:80] == '0, "error word carries sample or frame count")

endmodule

bind wav_stream_pcm_decoder wsd_checker u_wsd_checker (.*);

`default_nettype wire
